### rtl/ds402_enable_and_fault_reset_assert.svh
// assertion macros for the drive enable sequencer
`ifndef DS402_ENABLE_AND_FAULT_RESET_ASSERT_SVH
`define DS402_ENABLE_AND_FAULT_RESET_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define DS402_ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("ds402 assertion failed");

// condition holds in the cycle after the trigger
`define DS402_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("ds402 assertion failed");

`endif

### rtl/ds402_efr_pkg.sv
`default_nettype none
package ds402_efr_pkg;

  localparam logic [3:0] ST_NOTREADY   = 4'd0;
  localparam logic [3:0] ST_SWONDIS    = 4'd1;
  localparam logic [3:0] ST_READY      = 4'd2;
  localparam logic [3:0] ST_SWITCHEDON = 4'd3;
  localparam logic [3:0] ST_OPENABLED  = 4'd4;
  localparam logic [3:0] ST_QUICKSTOP  = 4'd5;
  localparam logic [3:0] ST_FREACTION  = 4'd6;
  localparam logic [3:0] ST_FAULT      = 4'd7;
  localparam logic [3:0] ST_UNKNOWN    = 4'd8;

  localparam logic CMD_ENABLE      = 1'b0;
  localparam logic CMD_FAULT_RESET = 1'b1;

  localparam logic [15:0] CW_NONE        = 16'h0000;
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_ENERGISE    = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
  localparam logic [15:0] CW_FAULT_ACK   = 16'h0080;

  localparam int unsigned SYNC_W   = 10;
  localparam int unsigned RCOUNT_W = 7;

  localparam logic [SYNC_W-1:0]   SYNC_HOLD_RESET = 10'd10;
  localparam logic [RCOUNT_W-1:0] RESET_ZERO_LAST  = 7'd5;
  localparam logic [RCOUNT_W-1:0] RESET_PULSE_LAST = 7'd15;
  localparam logic [RCOUNT_W-1:0] RESET_GIVE_UP    = 7'd100;

  typedef struct packed {
    logic               command;
    logic               frame_valid;
    logic [15:0]        status_word;
    logic signed [31:0] actual_counts;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        control_word;
    logic signed [31:0] target_counts;
    logic               target_written;
    logic               operation_enabled;
    logic [3:0]         drive_state_code;
    logic               reset_failed;
    logic               reset_in_progress;
  } out_item_t;

  function automatic logic [3:0] decode_status(input logic [15:0] sw);
    logic [3:0] st;
    if ((sw & 16'h004F) == 16'h000F) st = ST_FREACTION;
    else if (sw[3]) st = ST_FAULT;
    else if ((sw & 16'h004F) == 16'h0000) st = ST_NOTREADY;
    else if ((sw & 16'h006F) == 16'h0040) st = ST_SWONDIS;
    else if ((sw & 16'h006F) == 16'h0021) st = ST_READY;
    else if ((sw & 16'h006F) == 16'h0023) st = ST_SWITCHEDON;
    else if ((sw & 16'h006F) == 16'h0027) st = ST_OPENABLED;
    else if ((sw & 16'h0067) == 16'h0007) st = ST_QUICKSTOP;
    else st = ST_UNKNOWN;
    return st;
  endfunction

  // true in the pulse half of each 20-value period of the reset count
  function automatic logic pulse_phase(input logic [RCOUNT_W-1:0] c);
    return (c < 7'd10) ||
           ((c >= 7'd20) && (c < 7'd30)) ||
           ((c >= 7'd40) && (c < 7'd50)) ||
           ((c >= 7'd60) && (c < 7'd70)) ||
           ((c >= 7'd80) && (c < 7'd90)) ||
           ((c >= 7'd100) && (c < 7'd110)) ||
           (c >= 7'd120);
  endfunction

endpackage
`default_nettype wire

### rtl/ds402_efr_if.sv
`default_nettype none
interface ds402_efr_in_if;
  logic                   valid;
  logic                   ready;
  ds402_efr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ds402_efr_out_if;
  logic                    valid;
  logic                    ready;
  ds402_efr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ds402_efr_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [ds402_efr_pkg::SYNC_W-1:0]        data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/ds402_enable_and_fault_reset.sv
// drive enable and fault reset sequencer, master side of a ds402 drive
// in_ch: one transfer per bus cycle with command, frame_valid, statusword
//   and actual position; frame_valid low keeps the previously latched status
// out_ch: one result per input transfer with controlword, target position,
//   target_written, operation_enabled, drive state code and reset flags
// cfg_ch: writes sync_hold_cycles, always ready; the user must write only while the block is idle, not enforced here
// the result is registered and valid in the cycle after its input transfer
// throughput: one item per cycle when out_ch does not stall, set by the single decode and update
//   stage between the state registers and the result register
// when out_ch stalls the result register holds and in_ch.ready drops until
//   the result is taken; in_ch.ready is high whenever the result register
//   is empty or being taken in the same cycle
// reset (synchronous, rst_n low) clears all sequencer state, sets the drive
//   state to unknown and sync_hold_cycles to 10, and empties the output
`default_nettype none
module ds402_enable_and_fault_reset (
  input  wire logic      clk,
  input  wire logic      rst_n,
  ds402_efr_in_if.sink   in_ch,
  ds402_efr_out_if.source out_ch,
  ds402_efr_cfg_if.sink  cfg_ch
);
  import ds402_efr_pkg::*;

  `include "ds402_enable_and_fault_reset_assert.svh"

  logic [SYNC_W-1:0]   sync_hold_r;
  logic signed [31:0]  latched_actual_r, latched_actual_nxt;
  logic [3:0]          decoded_state_r, decoded_state_nxt;
  logic                sync_active_r, sync_active_nxt;
  logic [SYNC_W-1:0]   sync_count_r, sync_count_nxt;
  logic                reset_pending_r, reset_pending_nxt;
  logic [RCOUNT_W-1:0] reset_count_r, reset_count_nxt;
  logic [15:0]         held_control_r, held_control_nxt;
  logic signed [31:0]  held_target_r, held_target_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r, out_data_nxt;

  logic                in_xfer;
  logic                do_enable;
  logic                target_written;
  logic                op_enabled;
  logic                failed;
  logic [RCOUNT_W-1:0] rcount;
  logic [SYNC_W-1:0]   scount;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    latched_actual_nxt = latched_actual_r;
    decoded_state_nxt  = decoded_state_r;
    sync_active_nxt    = sync_active_r;
    sync_count_nxt     = sync_count_r;
    reset_pending_nxt  = reset_pending_r;
    reset_count_nxt    = reset_count_r;
    held_control_nxt   = held_control_r;
    held_target_nxt    = held_target_r;
    do_enable          = 1'b0;
    target_written     = 1'b0;
    op_enabled         = 1'b0;
    failed             = 1'b0;
    rcount             = '0;
    scount             = '0;

    if (in_ch.data.frame_valid) begin
      latched_actual_nxt = in_ch.data.actual_counts;
      decoded_state_nxt  = decode_status(in_ch.data.status_word);
    end

    if (in_ch.data.command == CMD_ENABLE) begin
      do_enable = 1'b1;
    end else begin
      rcount            = (reset_pending_r ? reset_count_r : '0) + RCOUNT_W'(1);
      reset_pending_nxt = 1'b1;
      reset_count_nxt   = rcount;
      if (rcount <= RESET_ZERO_LAST) begin
        held_control_nxt = CW_NONE;
      end else if (rcount <= RESET_PULSE_LAST) begin
        held_control_nxt = CW_FAULT_ACK;
      end else if (decoded_state_nxt != ST_FAULT && decoded_state_nxt != ST_FREACTION) begin
        reset_pending_nxt = 1'b0;
        reset_count_nxt   = '0;
        do_enable         = 1'b1;
      end else if (rcount > RESET_GIVE_UP) begin
        reset_pending_nxt = 1'b0;
        reset_count_nxt   = '0;
        failed            = 1'b1;
      end else begin
        held_control_nxt = pulse_phase(rcount) ? CW_FAULT_ACK : CW_NONE;
      end
    end

    if (do_enable) begin
      if (decoded_state_nxt != ST_SWITCHEDON) begin
        sync_active_nxt = 1'b0;
        sync_count_nxt  = '0;
      end
      case (decoded_state_nxt)
        ST_SWONDIS: begin
          held_control_nxt = CW_SHUTDOWN;
        end
        ST_READY: begin
          held_control_nxt = CW_ENERGISE;
        end
        ST_SWITCHEDON: begin
          scount          = sync_active_r ? sync_count_r : '0;
          sync_active_nxt = 1'b1;
          held_target_nxt = latched_actual_nxt;
          target_written  = 1'b1;
          if (scount < sync_hold_r) begin
            held_control_nxt = CW_ENERGISE;
            sync_count_nxt   = scount + SYNC_W'(1);
          end else begin
            held_control_nxt = CW_ENABLE_OP;
            sync_count_nxt   = scount;
          end
        end
        ST_OPENABLED: begin
          held_control_nxt = CW_ENABLE_OP;
          op_enabled       = 1'b1;
        end
        default: begin
        end
      endcase
    end

    out_data_nxt.control_word      = held_control_nxt;
    out_data_nxt.target_counts     = held_target_nxt;
    out_data_nxt.target_written    = target_written;
    out_data_nxt.operation_enabled = op_enabled;
    out_data_nxt.drive_state_code  = decoded_state_nxt;
    out_data_nxt.reset_failed      = failed;
    out_data_nxt.reset_in_progress = reset_pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_hold_r      <= SYNC_HOLD_RESET;
      latched_actual_r <= '0;
      decoded_state_r  <= ST_UNKNOWN;
      sync_active_r    <= 1'b0;
      sync_count_r     <= '0;
      reset_pending_r  <= 1'b0;
      reset_count_r    <= '0;
      held_control_r   <= '0;
      held_target_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        sync_hold_r <= cfg_ch.data;
      end
      if (in_xfer) begin
        latched_actual_r <= latched_actual_nxt;
        decoded_state_r  <= decoded_state_nxt;
        sync_active_r    <= sync_active_nxt;
        sync_count_r     <= sync_count_nxt;
        reset_pending_r  <= reset_pending_nxt;
        reset_count_r    <= reset_count_nxt;
        held_control_r   <= held_control_nxt;
        held_target_r    <= held_target_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  `DS402_ASSERT_NOW(a_fail_ends_reset, clk, rst_n, out_valid_r && out_data_r.reset_failed, !out_data_r.reset_in_progress)
  `DS402_ASSERT_NOW(a_target_in_swon, clk, rst_n, out_valid_r && out_data_r.target_written, out_data_r.drive_state_code == ST_SWITCHEDON)
  `DS402_ASSERT_NOW(a_openabled_cw, clk, rst_n, out_valid_r && out_data_r.operation_enabled, out_data_r.control_word == CW_ENABLE_OP)
  `DS402_ASSERT_NOW(a_reset_count_range, clk, rst_n, reset_pending_r, reset_count_r != '0 && reset_count_r <= RESET_GIVE_UP)

endmodule
`default_nettype wire
